[sv/pls_pkg.sv]
// shared types and constants for the periodic laplacian stencil
// no dependencies; imported by every module of the block except pls_grid_ram
package pls_pkg;

  localparam int MAX_ROWS = 128;
  localparam int MAX_COLS = 128;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int SIZE_W   = 8;
  localparam int AREA_W   = 24;
  localparam int DATA_W   = 32;
  localparam int ACC_W    = DATA_W + 3;
  localparam int LO_W     = 18;
  localparam int HI_W     = ACC_W - LO_W;
  localparam int PP_W     = LO_W + AREA_W;
  localparam int PROD_W   = ACC_W + AREA_W + 1;
  localparam int RES_W    = PROD_W - 16;
  localparam int CFG_IDX_W = 2;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS     = 2'd0,
    REG_GRID_COLS     = 2'd1,
    REG_INV_CELL_AREA = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DRAIN,
    ST_MUL,
    ST_WAIT,
    ST_EMIT
  } seq_state_e;

  // effective grid size after clamping
  typedef struct packed {
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;
  } grid_cfg_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] laplacian;
    logic              saturated;
    logic              bad_coordinate;
  } result_t;

endpackage

[sv/pls_grid_ram.sv]
// single-port synchronous grid memory, registered read data
// generic; no package dependency
module pls_grid_ram #(
  parameter int DEPTH  = 16384,
  parameter int DATA_W = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/pls_scale.sv]
// scaling unit: stencil sum times inverse cell area, round, saturate
// three register stages; depends on pls_pkg
module pls_scale import pls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ACC_W-1:0]  sum_i,
  input  logic [AREA_W-1:0] area_i,
  output logic              done_o,
  output logic [DATA_W-1:0] lap_o,
  output logic              sat_o
);

  logic [PP_W-1:0]        lo_p_q;
  logic signed [PP_W:0]   hi_p_q;
  logic [RES_W-1:0]       res_q;
  logic [DATA_W-1:0]      lap_q;
  logic                   sat_q;
  logic                   v1_q, v2_q, v3_q;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;
  logic                     over_pos, over_neg;

  // sum split into an unsigned low slice and a signed high slice
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      lo_p_q <= sum_i[LO_W-1:0] * area_i;
      hi_p_q <= $signed(sum_i[ACC_W-1:LO_W]) * $signed({1'b0, area_i});
    end
  end

  always_comb begin
    prod = (PROD_W'(hi_p_q) <<< LO_W) + $signed({{(PROD_W-PP_W){1'b0}}, lo_p_q});
    rnd  = prod + PROD_W'(32768);
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      res_q <= rnd[PROD_W-1:16];
    end
  end

  always_comb begin
    over_pos = !res_q[RES_W-1] && (|res_q[RES_W-2:DATA_W-1]);
    over_neg = res_q[RES_W-1] && !(&res_q[RES_W-2:DATA_W-1]);
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      sat_q <= over_pos || over_neg;
      if (over_pos) begin
        lap_q <= {1'b0, {(DATA_W-1){1'b1}}};
      end else if (over_neg) begin
        lap_q <= {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        lap_q <= res_q[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign done_o = v3_q;
  assign lap_o  = lap_q;
  assign sat_o  = sat_q;

endmodule

[sv/pls_seq.sv]
// item sequencer: decodes transactions, walks the five stencil reads,
// accumulates the sum and hands results on; depends on pls_pkg
module pls_seq import pls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  grid_cfg_t         cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [ROW_W-1:0]  row_i,
  input  logic [COL_W-1:0]  col_i,
  input  logic [DATA_W-1:0] cell_value_i,
  output ram_req_t          ram_req_o,
  input  logic [DATA_W-1:0] ram_rdata_i,
  output logic              scale_start_o,
  output logic [ACC_W-1:0]  scale_sum_o,
  input  logic              scale_done_i,
  input  logic [DATA_W-1:0] scale_lap_i,
  input  logic              scale_sat_i,
  output logic              emit_valid_o,
  input  logic              emit_ready_i,
  output result_t           emit_o
);

  seq_state_e state_q, state_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        bad_q, bad_d;
  logic        rd_vld_q, rd_ctr_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;

  logic [ROW_W-1:0] row_q, rm_q, rp_q;
  logic [COL_W-1:0] col_q, cm_q, cp_q;
  logic [ROW_W-1:0] rm, rp;
  logic [COL_W-1:0] cm, cp;
  logic             bad_in, accept;
  logic [SIZE_W-1:0] row_ext, col_ext;
  logic signed [ACC_W-1:0] rd_ext;

  always_comb begin
    row_ext = SIZE_W'(row_i);
    col_ext = SIZE_W'(col_i);
    bad_in  = (row_ext >= cfg_i.rows) || (col_ext >= cfg_i.cols);
    rm = (row_i == '0) ? ROW_W'(cfg_i.rows - SIZE_W'(1)) : row_i - ROW_W'(1);
    rp = (row_ext + SIZE_W'(1) == cfg_i.rows) ? '0 : row_i + ROW_W'(1);
    cm = (col_i == '0) ? COL_W'(cfg_i.cols - SIZE_W'(1)) : col_i - COL_W'(1);
    cp = (col_ext + SIZE_W'(1) == cfg_i.cols) ? '0 : col_i + COL_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q <= row_i;
      col_q <= col_i;
      rm_q  <= rm;
      rp_q  <= rp;
      cm_q  <= cm;
      cp_q  <= cp;
    end
  end

  always_comb begin
    rd_ext = ACC_W'($signed(ram_rdata_i));
    acc_d  = acc_q;
    if (accept) begin
      acc_d = '0;
    end else if (rd_vld_q) begin
      // centre enters with weight minus four
      acc_d = rd_ctr_q ? acc_q - (rd_ext <<< 2) : acc_q + rd_ext;
    end
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    bad_d         = bad_q;
    in_ready_o    = 1'b0;
    accept        = 1'b0;
    ram_req_o     = '0;
    scale_start_o = 1'b0;
    emit_valid_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        accept     = in_valid_i;
        ram_req_o.addr  = {row_i, col_i};
        ram_req_o.wdata = cell_value_i;
        if (in_valid_i) begin
          bad_d = bad_in;
          cnt_d = '0;
          if (bad_in) begin
            state_d = ST_EMIT;
          end else if (kind_i == KIND_WRITE) begin
            ram_req_o.we = 1'b1;
          end else begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        ram_req_o.re = 1'b1;
        case (cnt_q)
          3'd0:    ram_req_o.addr = {row_q, col_q};
          3'd1:    ram_req_o.addr = {rp_q, col_q};
          3'd2:    ram_req_o.addr = {rm_q, col_q};
          3'd3:    ram_req_o.addr = {row_q, cp_q};
          default: ram_req_o.addr = {row_q, cm_q};
        endcase
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        scale_start_o = 1'b1;
        state_d       = ST_WAIT;
      end
      ST_WAIT: begin
        if (scale_done_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        emit_valid_o = 1'b1;
        if (emit_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (bad_q) begin
      emit_o = '{laplacian: '0, saturated: 1'b0, bad_coordinate: 1'b1};
    end else begin
      emit_o = '{laplacian: scale_lap_i, saturated: scale_sat_i, bad_coordinate: 1'b0};
    end
  end

  assign scale_sum_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      bad_q    <= 1'b0;
      rd_vld_q <= 1'b0;
      rd_ctr_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      bad_q    <= bad_d;
      rd_vld_q <= ram_req_o.re;
      rd_ctr_q <= ram_req_o.re && (cnt_q == 3'd0);
      acc_q    <= acc_d;
    end
  end

endmodule

[sv/periodic_laplacian_stencil.sv]
// Five-point Laplacian on a periodic grid held in one single-port synchronous
// memory. A good cell write leaves the sequencer idle for the next transaction.
// In a Laplacian query the memory port reads centre, south, north, east and
// west in turn; then the sum is accumulated, run through the three-stage
// scaling multiplier and handed to the output register. A coordinate
// outside the grid skips the reads and the multiplier. The output
// register lets the next transaction in while a result waits to be taken.
// Depends on pls_pkg, pls_grid_ram, pls_scale and pls_seq.
module periodic_laplacian_stencil import pls_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [AREA_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic [ROW_W-1:0]     row_i,
  input  logic [COL_W-1:0]     col_i,
  input  logic signed [DATA_W-1:0] cell_value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [DATA_W-1:0] laplacian_o,
  output logic                 saturated_o,
  output logic                 bad_coordinate_o
);

  logic [SIZE_W-1:0] rows_q, cols_q;
  logic [AREA_W-1:0] area_q;
  grid_cfg_t         cfg;

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;
  logic              scale_start, scale_done, scale_sat;
  logic [ACC_W-1:0]  scale_sum;
  logic [DATA_W-1:0] scale_lap;
  logic              emit_valid, emit_ready;
  result_t           emit;

  logic              out_valid_q, out_valid_d;
  result_t           out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= SIZE_W'(MAX_ROWS);
      cols_q <= SIZE_W'(MAX_COLS);
      area_q <= AREA_W'(65536);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_GRID_ROWS:     rows_q <= cfg_wdata_i[SIZE_W-1:0];
        REG_GRID_COLS:     cols_q <= cfg_wdata_i[SIZE_W-1:0];
        REG_INV_CELL_AREA: area_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (rows_q == '0) begin
      cfg.rows = SIZE_W'(1);
    end else if (rows_q > SIZE_W'(MAX_ROWS)) begin
      cfg.rows = SIZE_W'(MAX_ROWS);
    end else begin
      cfg.rows = rows_q;
    end
    if (cols_q == '0) begin
      cfg.cols = SIZE_W'(1);
    end else if (cols_q > SIZE_W'(MAX_COLS)) begin
      cfg.cols = SIZE_W'(MAX_COLS);
    end else begin
      cfg.cols = cols_q;
    end
  end

  pls_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .cell_value_i  (cell_value_i),
    .ram_req_o     (ram_req),
    .ram_rdata_i   (ram_rdata),
    .scale_start_o (scale_start),
    .scale_sum_o   (scale_sum),
    .scale_done_i  (scale_done),
    .scale_lap_i   (scale_lap),
    .scale_sat_i   (scale_sat),
    .emit_valid_o  (emit_valid),
    .emit_ready_i  (emit_ready),
    .emit_o        (emit)
  );

  pls_grid_ram #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .re_i    (ram_req.re),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  pls_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scale_start),
    .sum_i   (scale_sum),
    .area_i  (area_q),
    .done_o  (scale_done),
    .lap_o   (scale_lap),
    .sat_o   (scale_sat)
  );

  assign emit_ready  = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_valid && emit_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_valid && emit_ready) begin
      out_q <= emit;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign laplacian_o      = $signed(out_q.laplacian);
  assign saturated_o      = out_q.saturated;
  assign bad_coordinate_o = out_q.bad_coordinate;

endmodule

[sv/pls_checker.sv]
// port-level checks for the periodic laplacian stencil, bound to the top
// depends on pls_pkg and periodic_laplacian_stencil
module pls_checker import pls_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     kind_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [DATA_W-1:0] laplacian_o,
  input logic                     saturated_o,
  input logic                     bad_coordinate_o
);

  // a waiting result is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(laplacian_o))
    else $error("result changed while stalled");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_coordinate_o |-> laplacian_o == '0 && !saturated_o)
    else $error("bad coordinate result not cleared");

  a_sat_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      laplacian_o == 32'sh7fffffff || laplacian_o == -32'sh80000000)
    else $error("saturated result not at a rail");

  // a query occupies the memory port, so no new transaction is taken right behind it
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i == KIND_READ |=> !in_ready_o)
    else $error("transaction taken during a query");

endmodule

bind periodic_laplacian_stencil pls_checker u_pls_checker (.*);

[sim/laplacian_checker.sv]
`timescale 1ns / 1ps
// scoreboard for the periodic laplacian stencil: mirrors the grid and the
// registers, predicts each result and compares it field by field
// depends on pls_pkg only
module laplacian_checker import pls_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [AREA_W-1:0]        cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic                     kind_i,
  input  logic [ROW_W-1:0]         row_i,
  input  logic [COL_W-1:0]         col_i,
  input  logic signed [DATA_W-1:0] cell_value_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [DATA_W-1:0] laplacian_i,
  input  logic                     saturated_i,
  input  logic                     bad_coordinate_i,
  output int                       pending_o,
  output int                       failures_o,
  output int                       compared_o
);

  localparam longint Q_MAX       = 64'sd2147483647;
  localparam longint Q_MIN       = -Q_MAX - 1;
  localparam longint HALF_LSB    = 64'sd32768;
  localparam int     MAX_REPORTS = 30;

  logic signed [DATA_W-1:0] grid_mirror [DEPTH];
  logic [SIZE_W-1:0] rows_reg = SIZE_W'(MAX_ROWS);
  logic [SIZE_W-1:0] cols_reg = SIZE_W'(MAX_COLS);
  logic [AREA_W-1:0] area_reg = AREA_W'(65536);
  result_t           expected_q [$];
  result_t           got, want;
  int                fail_cnt = 0;
  int                cmp_cnt = 0;

  function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] v,
                                             input int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return 32'(v);
  endfunction

  function automatic longint cell_at(input int unsigned r, input int unsigned c);
    return longint'(grid_mirror[ADDR_W'(r * MAX_COLS + c)]);
  endfunction

  function automatic result_t laplacian_at(input int unsigned r, input int unsigned c);
    int unsigned nr, nc, up, dn, lf, rt;
    longint      stencil, scaled;
    result_t     res;
    nr = clamp_size(rows_reg, MAX_ROWS);
    nc = clamp_size(cols_reg, MAX_COLS);
    up = (r == 0) ? nr - 1 : r - 1;
    dn = (r + 1 == nr) ? 0 : r + 1;
    lf = (c == 0) ? nc - 1 : c - 1;
    rt = (c + 1 == nc) ? 0 : c + 1;
    stencil = cell_at(up, c) + cell_at(dn, c) + cell_at(r, lf) + cell_at(r, rt)
              - 4 * cell_at(r, c);
    // add half an lsb then floor, so ties go towards plus infinity
    scaled = (stencil * longint'(area_reg) + HALF_LSB) >>> 16;
    res = '0;
    if (scaled > Q_MAX) begin
      scaled = Q_MAX;
      res.saturated = 1'b1;
    end else if (scaled < Q_MIN) begin
      scaled = Q_MIN;
      res.saturated = 1'b1;
    end
    res.laplacian = scaled[DATA_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic signed [DATA_W-1:0] want_v,
                             input logic signed [DATA_W-1:0] got_v);
    if (got_v !== want_v) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_reg = SIZE_W'(MAX_ROWS);
      cols_reg = SIZE_W'(MAX_COLS);
      area_reg = AREA_W'(65536);
      expected_q.delete();
      pending_o  <= 0;
      failures_o <= fail_cnt;
      compared_o <= cmp_cnt;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_GRID_ROWS:     rows_reg = cfg_wdata_i[SIZE_W-1:0];
          REG_GRID_COLS:     cols_reg = cfg_wdata_i[SIZE_W-1:0];
          REG_INV_CELL_AREA: area_reg = cfg_wdata_i;
          default: ;
        endcase
      end

      // results first, so a transaction taken on this edge is never matched here
      if (out_valid_i && out_ready_i) begin
        got = {laplacian_i, saturated_i, bad_coordinate_i};
        if (expected_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result: expected none, got laplacian %0d sat %0b bad %0b",
                     $time, $signed(got.laplacian), got.saturated, got.bad_coordinate);
        end else begin
          want = expected_q.pop_front();
          cmp_cnt++;
          check_field("laplacian", want.laplacian, got.laplacian);
          check_field("saturated", DATA_W'(want.saturated), DATA_W'(got.saturated));
          check_field("bad_coordinate", DATA_W'(want.bad_coordinate),
                      DATA_W'(got.bad_coordinate));
        end
      end

      if (in_valid_i && in_ready_i) begin
        if (row_i >= clamp_size(rows_reg, MAX_ROWS) || col_i >= clamp_size(cols_reg, MAX_COLS))
        begin
          want = '0;
          want.bad_coordinate = 1'b1;
          expected_q.push_back(want);
        end else if (kind_i == KIND_WRITE) begin
          grid_mirror[{row_i, col_i}] = cell_value_i;
        end else begin
          expected_q.push_back(laplacian_at(32'(row_i), 32'(col_i)));
        end
      end

      pending_o  <= expected_q.size();
      failures_o <= fail_cnt;
      compared_o <= cmp_cnt;
    end
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// stimulus and verdict for the periodic laplacian stencil: directed wrap,
// saturation, rounding and off-grid cases, then random traffic over many grid settings
// depends on pls_pkg, periodic_laplacian_stencil and laplacian_checker
module testbench import pls_pkg::*; ();

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int                  SETTLE_CYCLES = 30;
  localparam logic [DATA_W-1:0]   Q_MAX_WORD  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0]   Q_MIN_WORD  = 32'h8000_0000;
  localparam logic [DATA_W-1:0]   Q_PLUS_LSB  = 32'h0000_0001;
  localparam logic [DATA_W-1:0]   Q_MINUS_LSB = 32'hFFFF_FFFF;
  localparam logic [AREA_W-1:0]   AREA_ZERO   = 24'h00_0000;
  localparam logic [AREA_W-1:0]   AREA_HALF   = 24'h00_8000;
  localparam logic [AREA_W-1:0]   AREA_UNIT   = 24'h01_0000;
  localparam logic [AREA_W-1:0]   AREA_MAX    = 24'hFF_FFFF;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index_i = REG_GRID_ROWS;
  logic [AREA_W-1:0]        cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic                     kind_i = KIND_WRITE;
  logic [ROW_W-1:0]         row_i = '0;
  logic [COL_W-1:0]         col_i = '0;
  logic signed [DATA_W-1:0] cell_value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] laplacian_o;
  logic                     saturated_o;
  logic                     bad_coordinate_o;

  int pending, failures, compared;

  int unsigned grid_rows_eff = MAX_ROWS;
  int unsigned grid_cols_eff = MAX_COLS;
  bit          cell_written [DEPTH];
  int          in_gap_pct = 0;
  int          out_stall_pct = 0;
  int          stall_left = 0;
  int          n_items = 0;
  int          n_writes = 0;
  int          n_queries = 0;
  int          n_offgrid = 0;
  int          n_settings = 0;

  periodic_laplacian_stencil dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .kind_i, .row_i, .col_i, .cell_value_i,
    .out_valid_o, .out_ready_i, .laplacian_o, .saturated_o, .bad_coordinate_o
  );

  laplacian_checker lap_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .row_i, .col_i, .cell_value_i,
    .out_valid_i(out_valid_o), .out_ready_i, .laplacian_i(laplacian_o),
    .saturated_i(saturated_o), .bad_coordinate_i(bad_coordinate_o),
    .pending_o(pending), .failures_o(failures), .compared_o(compared)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver back-pressure in random bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 99) < out_stall_pct) begin
      stall_left  <= $urandom_range(0, 9);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 50;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return Q_MAX_WORD;
      1:       return Q_MIN_WORD;
      2:       return $urandom_range(0, 1023) - 512;
      default: return $urandom;
    endcase
  endfunction

  // edges and a small corner window keep neighbourhoods reused
  function automatic int unsigned pick_coord(input int unsigned limit);
    case ($urandom_range(0, 3))
      0:       return limit - 1;
      1:       return 0;
      2:       return $urandom_range(0, (limit < 8) ? limit - 1 : 7);
      default: return $urandom_range(0, limit - 1);
    endcase
  endfunction

  task automatic send_item(input logic kind, input logic [ROW_W-1:0] r,
                           input logic [COL_W-1:0] c, input logic [DATA_W-1:0] v);
    if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    row_i        <= r;
    col_i        <= c;
    cell_value_i <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_items++;
    if (r >= grid_rows_eff || c >= grid_cols_eff) begin
      n_offgrid++;
    end else if (kind == KIND_WRITE) begin
      n_writes++;
      cell_written[{r, c}] = 1'b1;
    end else begin
      n_queries++;
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // a trailing cell write gives no result to wait for
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [SIZE_W-1:0] rows_w, input logic [SIZE_W-1:0] cols_w,
                               input logic [AREA_W-1:0] area_w);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_GRID_ROWS;
    cfg_wdata_i <= {16'($urandom), rows_w};
    @(posedge clk_i);
    cfg_index_i <= REG_GRID_COLS;
    cfg_wdata_i <= {16'($urandom), cols_w};
    @(posedge clk_i);
    cfg_index_i <= REG_INV_CELL_AREA;
    cfg_wdata_i <= area_w;
    @(posedge clk_i);
    // no register behind this index, settings must stay as they are
    cfg_index_i <= REG_UNUSED;
    cfg_wdata_i <= 24'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    grid_rows_eff = (rows_w == 0) ? 1 : ((rows_w > MAX_ROWS) ? MAX_ROWS : 32'(rows_w));
    grid_cols_eff = (cols_w == 0) ? 1 : ((cols_w > MAX_COLS) ? MAX_COLS : 32'(cols_w));
    n_settings++;
  endtask

  // fills any unwritten cell of the stencil first, or all five when refresh is set
  task automatic query_cell(input int unsigned r, input int unsigned c, input bit refresh);
    int unsigned nb_r [5];
    int unsigned nb_c [5];
    nb_r = '{r, (r == 0) ? grid_rows_eff - 1 : r - 1, (r + 1 == grid_rows_eff) ? 0 : r + 1, r, r};
    nb_c = '{c, c, c, (c == 0) ? grid_cols_eff - 1 : c - 1, (c + 1 == grid_cols_eff) ? 0 : c + 1};
    for (int i = 0; i < 5; i++)
      if (refresh || !cell_written[{nb_r[i][ROW_W-1:0], nb_c[i][COL_W-1:0]}])
        send_item(KIND_WRITE, nb_r[i][ROW_W-1:0], nb_c[i][COL_W-1:0], pick_value());
    send_item(KIND_READ, r[ROW_W-1:0], c[COL_W-1:0], $urandom);
  endtask

  task automatic send_offgrid();
    int unsigned r, c;
    r = $urandom_range(0, MAX_ROWS - 1);
    c = $urandom_range(0, MAX_COLS - 1);
    if (grid_rows_eff < MAX_ROWS && (grid_cols_eff == MAX_COLS || $urandom_range(0, 1)))
      r = $urandom_range(grid_rows_eff, MAX_ROWS - 1);
    else if (grid_cols_eff < MAX_COLS)
      c = $urandom_range(grid_cols_eff, MAX_COLS - 1);
    else
      return;
    send_item(logic'($urandom_range(0, 1)), r[ROW_W-1:0], c[COL_W-1:0], $urandom);
  endtask

  task automatic random_traffic(input int count, input bit quiet);
    int first, iter;
    first = n_items;
    iter  = 0;
    while (n_items - first < count) begin
      if (iter % 25 == 0) begin
        in_gap_pct    = quiet ? 0 : pick_pct();
        out_stall_pct <= quiet ? 0 : pick_pct();
      end
      iter++;
      case ($urandom_range(0, 9))
        0, 1, 2: send_item(KIND_WRITE, ROW_W'($urandom_range(0, grid_rows_eff - 1)),
                           COL_W'($urandom_range(0, grid_cols_eff - 1)), pick_value());
        3, 4, 5: query_cell(pick_coord(grid_rows_eff), pick_coord(grid_cols_eff), 1'b0);
        6, 7:    query_cell(pick_coord(grid_rows_eff), pick_coord(grid_cols_eff), 1'b1);
        default: send_offgrid();
      endcase
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full grid, wrap on every side: the first query has its centre at one extreme, neighbours at the other
    send_item(KIND_WRITE, 7'd0, 7'd0, Q_MIN_WORD);
    send_item(KIND_WRITE, 7'd1, 7'd0, Q_MAX_WORD);
    send_item(KIND_WRITE, 7'd127, 7'd0, Q_MAX_WORD);
    send_item(KIND_WRITE, 7'd0, 7'd1, Q_MAX_WORD);
    send_item(KIND_WRITE, 7'd0, 7'd127, Q_MAX_WORD);
    send_item(KIND_READ, 7'd0, 7'd0, '0);
    send_item(KIND_WRITE, 7'd127, 7'd127, Q_MAX_WORD);
    send_item(KIND_WRITE, 7'd126, 7'd127, Q_MIN_WORD);
    send_item(KIND_WRITE, 7'd127, 7'd126, Q_MIN_WORD);
    send_item(KIND_READ, 7'd127, 7'd127, '1);

    // 3x2 grid at half scale: +1/2 lsb rounds to 1, -1/2 lsb rounds to 0
    apply_setting(8'd3, 8'd2, AREA_HALF);
    send_item(KIND_WRITE, 7'd0, 7'd0, '0);
    send_item(KIND_WRITE, 7'd1, 7'd0, Q_PLUS_LSB);
    send_item(KIND_WRITE, 7'd2, 7'd0, '0);
    send_item(KIND_WRITE, 7'd0, 7'd1, '0);
    send_item(KIND_READ, 7'd0, 7'd0, '0);
    send_item(KIND_WRITE, 7'd1, 7'd0, Q_MINUS_LSB);
    send_item(KIND_READ, 7'd0, 7'd0, '0);
    // off-grid writes must not land in the store
    send_item(KIND_WRITE, 7'd127, 7'd0, Q_MIN_WORD);
    send_item(KIND_READ, 7'd0, 7'd127, '0);
    send_item(KIND_READ, 7'd3, 7'd1, '0);
    send_item(KIND_WRITE, 7'd2, 7'd2, Q_MAX_WORD);

    random_traffic(80, 1'b0);
    apply_setting(8'd128, 8'd128, AREA_UNIT);
    random_traffic(60, 1'b0);
    apply_setting(8'd1, 8'd1, AREA_MAX);
    random_traffic(60, 1'b0);
    apply_setting(8'd0, 8'd0, AREA_ZERO);
    random_traffic(40, 1'b0);
    apply_setting(8'd255, 8'd200, AREA_MAX);
    random_traffic(150, 1'b0);
    apply_setting(8'd128, 8'd1, 24'($urandom));
    random_traffic(100, 1'b0);
    apply_setting(8'd1, 8'd128, 24'($urandom_range(0, 2 * AREA_UNIT)));
    random_traffic(100, 1'b0);
    for (int p = 0; p < 3; p++) begin
      apply_setting(8'($urandom_range(1, MAX_ROWS)), 8'($urandom_range(1, MAX_COLS)),
                    (p == 0) ? 24'($urandom) : 24'($urandom_range(0, 24'h03_FFFF)));
      random_traffic(120, 1'b0);
    end
    // last stretch runs with both sides flat out
    apply_setting(8'($urandom_range(2, 16)), 8'($urandom_range(2, 16)),
                  AREA_UNIT + 24'($urandom_range(0, 4095)));
    random_traffic(150, 1'b1);

    drain_results();
    $display("covered %0d transactions: %0d cell writes, %0d queries, %0d off the grid",
             n_items, n_writes, n_queries, n_offgrid);
    $display("%0d results compared across %0d register settings", compared, n_settings);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("timeout: the block stopped taking or returning transactions");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
